FILE: design/fba_pkg.sv
// fba_pkg: shared types and constants for the frame bitmap allocator
// transaction structs, status codes and the sequencer state type
// no dependencies
package fba_pkg;

	// bits per bitmap word and the fixed field widths
	localparam int WORD_BITS  = 32;
	localparam int BIT_W      = 5;
	localparam int FRAME_W    = 12;
	localparam int STATUS_W   = 3;
	localparam int WIU_W      = 8;
	localparam logic [WIU_W-1:0] WIU_RESET = 8'd128;

	// result status codes
	localparam logic [STATUS_W-1:0] STAT_ALLOCATED = 3'd0;
	localparam logic [STATUS_W-1:0] STAT_ALREADY   = 3'd1;
	localparam logic [STATUS_W-1:0] STAT_FREED     = 3'd2;
	localparam logic [STATUS_W-1:0] STAT_NOTHING   = 3'd3;
	localparam logic [STATUS_W-1:0] STAT_NO_FRAMES = 3'd4;

	// request modes
	localparam logic MODE_ALLOC = 1'b0;
	localparam logic MODE_FREE  = 1'b1;

	localparam logic [WORD_BITS-1:0] WORD_FULL = 32'hFFFF_FFFF;

	// input transaction
	typedef struct packed {
		logic               mode;
		logic [FRAME_W-1:0] page_frame;
		logic               kernel_page;
		logic               wants_write;
	} in_t;

	// result transaction
	typedef struct packed {
		logic [FRAME_W-1:0]  frame;
		logic                present;
		logic                writable;
		logic                user_access;
		logic [STATUS_W-1:0] status;
	} out_t;

	// sequencer states
	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_SCAN,
		S_FREE,
		S_PUT
	} state_t;

endpackage

FILE: design/fba_bitmap_ram.sv
// fba_bitmap_ram: bitmap word store, one write port and one registered read port
// depends on fba_pkg for the word width
module fba_bitmap_ram
	import fba_pkg::*;
#(
	parameter int DEPTH = 128,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                 clk,
	input  logic                 wr_en,
	input  logic [AW-1:0]        wr_addr,
	input  logic [WORD_BITS-1:0] wr_data,
	input  logic                 rd_en,
	input  logic [AW-1:0]        rd_addr,
	output logic [WORD_BITS-1:0] rd_data
);

	logic [WORD_BITS-1:0] mem [DEPTH];
	logic [WORD_BITS-1:0] rd_data_q;

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

FILE: design/fba_zero_find.sv
// fba_zero_find: lowest clear bit of one bitmap word, as a halving tree
// depends on fba_pkg for word and index widths
module fba_zero_find
	import fba_pkg::*;
(
	input  logic [WORD_BITS-1:0] word,
	output logic                 found,
	output logic [BIT_W-1:0]     idx
);

	logic [31:0] free_bits;
	logic [15:0] l16;
	logic [7:0]  l8;
	logic [3:0]  l4;
	logic [1:0]  l2;

	// each level keeps the lower half if it holds a free frame
	always_comb begin
		free_bits = ~word;
		idx[4]    = ~(|free_bits[15:0]);
		l16       = idx[4] ? free_bits[31:16] : free_bits[15:0];
		idx[3]    = ~(|l16[7:0]);
		l8        = idx[3] ? l16[15:8] : l16[7:0];
		idx[2]    = ~(|l8[3:0]);
		l4        = idx[2] ? l8[7:4] : l8[3:0];
		idx[1]    = ~(|l4[1:0]);
		l2        = idx[1] ? l4[3:2] : l4[1:0];
		idx[0]    = ~l2[0];
		found     = |free_bits;
	end

endmodule

FILE: design/frame_bitmap_allocator.sv
// frame_bitmap_allocator: first-fit page frame allocator over a word bitmap
// depends on fba_pkg, fba_bitmap_ram and fba_zero_find
//
//  channel  | signals                          | direction | moves
//  ---------+----------------------------------+-----------+--------------------------
//  in       | in_valid, in_stall, in_data      | into      | alloc / free request
//  out      | out_valid, out_stall, out_data   | out of    | frame, entry bits, status
//  cfg      | cfg_wr_en, cfg_wr_data           | into      | words_in_use register
//
// an allocate of frame zero searches word by word from word 0 for a clear bit
// (one word per cycle through the read port and zero finder) and takes the
// first one; it ends out of frames when none of the words searched is free
// after reset a clearing pass writes zero to every word, with in_stall high
// throughout; configuration writes are taken as ever
// a request is taken while an earlier result waits in the output register
module frame_bitmap_allocator
	import fba_pkg::*;
#(
	parameter int MAX_WORDS = 128
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  in_t              in_data,
	output logic             out_valid,
	input  logic             out_stall,
	output out_t             out_data,
	input  logic             cfg_wr_en,
	input  logic [WIU_W-1:0] cfg_wr_data
);

	localparam int AW = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
	localparam int CW = $clog2(MAX_WORDS + 1);
	localparam int LW = (CW > WIU_W) ? CW : WIU_W;
	localparam logic [LW-1:0] MAX_L  = LW'(MAX_WORDS);
	localparam logic [AW-1:0] LAST_A = AW'(MAX_WORDS - 1);

	state_t state_q, state_d;

	logic [WIU_W-1:0]     wiu_q;
	logic [AW-1:0]        clr_q;
	logic [LW-1:0]        w_q;
	logic [LW-1:0]        limit_q;
	logic                 rvalid_q;
	logic [AW-1:0]        ra_q;
	logic [AW-1:0]        fa_q;
	logic [BIT_W-1:0]     fb_q;
	logic                 wr_q;
	logic                 usr_q;
	out_t                 res_q;
	out_t                 out_q;
	logic                 out_valid_q;

	logic                 accept;
	logic                 issue;
	logic [LW-1:0]        wiu_l;
	logic [LW-1:0]        req_word_l;
	logic                 req_in_map;
	logic [AW-1:0]        req_addr;
	logic                 mem_we;
	logic [AW-1:0]        mem_waddr;
	logic [WORD_BITS-1:0] mem_wdata;
	logic                 mem_re;
	logic [AW-1:0]        mem_raddr;
	logic [WORD_BITS-1:0] mem_rdata;
	logic                 zf_found;
	logic [BIT_W-1:0]     zf_idx;
	logic                 put_ok;

	assign accept     = in_valid && !in_stall;
	assign in_stall   = (state_q != S_IDLE);
	assign out_valid  = out_valid_q;
	assign out_data   = out_q;
	assign issue      = (state_q == S_SCAN) && (w_q < limit_q);
	assign wiu_l      = LW'(wiu_q);
	assign req_word_l = LW'(in_data.page_frame[FRAME_W-1:BIT_W]);
	assign req_in_map = req_word_l < MAX_L;
	assign req_addr   = req_word_l[AW-1:0];
	assign put_ok     = !out_valid_q || !out_stall;

	// bitmap store and the zero finder
	fba_bitmap_ram #(
		.DEPTH(MAX_WORDS)
	) u_ram (
		.clk     (clk),
		.wr_en   (mem_we),
		.wr_addr (mem_waddr),
		.wr_data (mem_wdata),
		.rd_en   (mem_re),
		.rd_addr (mem_raddr),
		.rd_data (mem_rdata)
	);

	fba_zero_find u_zf (
		.word  (mem_rdata),
		.found (zf_found),
		.idx   (zf_idx)
	);

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wiu_q <= WIU_RESET;
		end else if (cfg_wr_en) begin
			wiu_q <= cfg_wr_data;
		end
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and bitmap port control
	always_comb begin
		state_d   = state_q;
		mem_we    = 1'b0;
		mem_waddr = clr_q;
		mem_wdata = '0;
		mem_re    = 1'b0;
		mem_raddr = w_q[AW-1:0];
		unique case (state_q)
			S_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				if (clr_q == LAST_A) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				mem_re    = 1'b1;
				mem_raddr = req_addr;
				if (accept) begin
					if (in_data.mode == MODE_ALLOC) begin
						state_d = (in_data.page_frame != '0) ? S_PUT : S_SCAN;
					end else if (in_data.page_frame != '0 && req_in_map) begin
						state_d = S_FREE;
					end else begin
						state_d = S_PUT;
					end
				end
			end
			S_SCAN: begin
				mem_re    = issue;
				mem_raddr = w_q[AW-1:0];
				if (rvalid_q && zf_found) begin
					mem_we    = 1'b1;
					mem_waddr = ra_q;
					mem_wdata = mem_rdata | (WORD_BITS'(1) << zf_idx);
					state_d   = S_PUT;
				end else if (!rvalid_q && !issue) begin
					state_d = S_PUT;
				end
			end
			S_FREE: begin
				mem_we    = 1'b1;
				mem_waddr = fa_q;
				mem_wdata = mem_rdata & ~(WORD_BITS'(1) << fb_q);
				state_d   = S_PUT;
			end
			S_PUT: begin
				if (put_ok) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// clearing pass counter and scan pipeline control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q    <= '0;
			w_q      <= '0;
			rvalid_q <= 1'b0;
		end else begin
			if (state_q == S_CLEAR) begin
				clr_q <= clr_q + AW'(1);
			end
			if (accept) begin
				w_q <= '0;
			end else if (issue) begin
				w_q <= w_q + LW'(1);
			end
			rvalid_q <= issue;
		end
	end

	// request and result payload
	always_ff @(posedge clk) begin
		ra_q <= w_q[AW-1:0];
		if (accept) begin
			limit_q <= (wiu_l > MAX_L) ? MAX_L : wiu_l;
			fa_q    <= req_addr;
			fb_q    <= in_data.page_frame[BIT_W-1:0];
			wr_q    <= in_data.wants_write;
			usr_q   <= ~in_data.kernel_page;
			if (in_data.mode == MODE_ALLOC) begin
				res_q <= '{frame: in_data.page_frame, present: 1'b0, writable: 1'b0,
					user_access: 1'b0, status: STAT_ALREADY};
			end else if (in_data.page_frame == '0) begin
				res_q <= '{frame: '0, present: 1'b0, writable: 1'b0,
					user_access: 1'b0, status: STAT_NOTHING};
			end else begin
				res_q <= '{frame: '0, present: 1'b0, writable: 1'b0,
					user_access: 1'b0, status: STAT_FREED};
			end
		end else if (state_q == S_SCAN) begin
			if (rvalid_q && zf_found) begin
				res_q <= '{frame: FRAME_W'({ra_q, zf_idx}), present: 1'b1,
					writable: wr_q, user_access: usr_q, status: STAT_ALLOCATED};
			end else if (!rvalid_q && !issue) begin
				res_q <= '{frame: '0, present: 1'b0, writable: 1'b0,
					user_access: 1'b0, status: STAT_NO_FRAMES};
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_PUT && put_ok) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_PUT && put_ok) begin
			out_q <= res_q;
		end
	end

	// checks on the sequencer
	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q != S_IDLE)
		else $error("accepted transaction did not start work");

	a_no_result_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CLEAR |-> !out_valid)
		else $error("result during clearing pass");

	a_idle_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> !mem_we)
		else $error("bitmap written while idle");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SCAN |-> w_q <= limit_q && limit_q <= MAX_L)
		else $error("scan ran past the word limit");

	a_no_frames_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status == STAT_NO_FRAMES |->
		out_data.frame == '0 && !out_data.present)
		else $error("out-of-frames result carries a frame");

endmodule

FILE: verif/fba_alloc_checker.sv
// fba_alloc_checker: watches the request, result and register channels of the
// frame bitmap allocator, keeps its own bitmap and compares every result
// depends on fba_pkg
module fba_alloc_checker
	import fba_pkg::*;
#(
	parameter int MAX_WORDS = 128
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             in_stall,
	input  in_t              in_data,
	input  logic             out_valid,
	input  logic             out_stall,
	input  out_t             out_data,
	input  logic             cfg_wr_en,
	input  logic [WIU_W-1:0] cfg_wr_data,
	output int               mismatches,
	output int               pending,
	output int               results_checked,
	output int               no_frames_seen,
	output int               frees_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	// own copy of the frame bitmap and the searched word count
	logic [WORD_BITS-1:0] frame_map [MAX_WORDS];
	logic [WIU_W-1:0]     word_count = WIU_RESET;
	out_t                 awaited_results [$];
	int                   fail_count = 0;
	int                   checked = 0;
	int                   full_count = 0;
	int                   free_count = 0;

	// first-fit allocate or free, updating the bitmap as the block should
	function automatic out_t serve_request(in_t req);
		out_t res;
		int   span;
		logic found;
		res   = '0;
		found = 1'b0;
		span  = (word_count > MAX_WORDS) ? MAX_WORDS : int'(word_count);
		if (req.mode == MODE_ALLOC) begin
			if (req.page_frame != '0) begin
				res.frame  = req.page_frame;
				res.status = STAT_ALREADY;
			end else begin
				res.status = STAT_NO_FRAMES;
				for (int w = 0; w < span; w++)
					for (int b = 0; b < WORD_BITS; b++)
						if (!found && !frame_map[w][b]) begin
							found          = 1'b1;
							frame_map[w][b] = 1'b1;
							res.frame       = FRAME_W'(w * WORD_BITS + b);
							res.present     = 1'b1;
							res.writable    = req.wants_write;
							res.user_access = ~req.kernel_page;
							res.status      = STAT_ALLOCATED;
						end
			end
		end else if (req.page_frame == '0) begin
			res.status = STAT_NOTHING;
		end else begin
			// frames whose word lies past the bitmap are left alone
			if (int'(req.page_frame / WORD_BITS) < MAX_WORDS)
				frame_map[req.page_frame / WORD_BITS][req.page_frame % WORD_BITS] = 1'b0;
			res.status = STAT_FREED;
		end
		return res;
	endfunction

	function automatic void check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			fail_count++;
			$display("%0t ns: result %s mismatch, expected %0d, actual %0d",
				$time, name, want, got);
		end
	endfunction

	// sample all channels at the clock edge, results before new requests
	always @(posedge clk) begin
		out_t want;
		if (!arst_n) begin
			for (int w = 0; w < MAX_WORDS; w++)
				frame_map[w] = '0;
			word_count = WIU_RESET;
			awaited_results.delete();
		end else begin
			if (cfg_wr_en)
				word_count = cfg_wr_data;
			if (out_valid && !out_stall) begin
				if (awaited_results.size() == 0) begin
					fail_count++;
					$display("%0t ns: result transaction with none expected, actual %h",
						$time, out_data);
				end else begin
					want = awaited_results.pop_front();
					check_field("frame", want.frame, out_data.frame);
					check_field("present", want.present, out_data.present);
					check_field("writable", want.writable, out_data.writable);
					check_field("user_access", want.user_access, out_data.user_access);
					check_field("status", want.status, out_data.status);
					checked++;
					if (want.status == STAT_NO_FRAMES)
						full_count++;
					if (want.status == STAT_FREED)
						free_count++;
				end
			end
			if (in_valid && !in_stall)
				awaited_results.push_back(serve_request(in_data));
		end
		mismatches      <= fail_count;
		pending         <= awaited_results.size();
		results_checked <= checked;
		no_frames_seen  <= full_count;
		frees_seen      <= free_count;
	end

endmodule

FILE: verif/frame_bitmap_allocator_tb.sv
// frame_bitmap_allocator_tb: stimulus, flow control and verdict for the
// frame bitmap allocator; results are checked by fba_alloc_checker
// depends on fba_pkg, frame_bitmap_allocator and fba_alloc_checker
module frame_bitmap_allocator_tb;
	import fba_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_WORDS    = 128;
	localparam int PHASES       = 6;
	localparam int PHASE_ITEMS  = 115;
	localparam int HOLD_CYCLES  = 600;
	localparam int IDLE_LIMIT   = 5000;
	localparam int TAIL_CYCLES  = 20;
	localparam int FRAME_MAX    = (1 << FRAME_W) - 1;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             in_valid = 1'b0;
	logic             in_stall;
	in_t              in_data = '0;
	logic             out_valid;
	logic             out_stall = 1'b0;
	out_t             out_data;
	logic             cfg_wr_en = 1'b0;
	logic [WIU_W-1:0] cfg_wr_data = '0;

	int   mismatches, pending, results_checked, no_frames_seen, frees_seen;
	logic hold_req = 1'b0;
	int   burst_left = 0;
	int   sent = 0;
	int   idle_cycles = 0;
	logic [WIU_W-1:0] phase_count [PHASES];

	frame_bitmap_allocator #(.MAX_WORDS(MAX_WORDS)) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.in_data     (in_data),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_data    (out_data),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	fba_alloc_checker #(.MAX_WORDS(MAX_WORDS)) checker_i (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.in_data         (in_data),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.out_data        (out_data),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_wr_data     (cfg_wr_data),
		.mismatches      (mismatches),
		.pending         (pending),
		.results_checked (results_checked),
		.no_frames_seen  (no_frames_seen),
		.frees_seen      (frees_seen)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	function automatic in_t make_req(logic mode, int unsigned frame, logic kernel, logic wr);
		in_t r;
		r.mode        = mode;
		r.page_frame  = FRAME_W'(frame);
		r.kernel_page = kernel;
		r.wants_write = wr;
		return r;
	endfunction

	// mostly allocate/free traffic inside the searched frames, some noise
	function automatic in_t random_req(logic [WIU_W-1:0] words);
		int unsigned pick, span;
		in_t         r;
		pick          = $urandom_range(0, 99);
		span          = (words == 0) ? 1 : ((words > 8) ? 8 : words);
		r.kernel_page = 1'($urandom_range(0, 1));
		r.wants_write = 1'($urandom_range(0, 1));
		if (pick < 55) begin
			r.mode       = MODE_ALLOC;
			r.page_frame = '0;
		end else if (pick < 65) begin
			r.mode       = MODE_ALLOC;
			r.page_frame = FRAME_W'($urandom_range(1, FRAME_MAX));
		end else if (pick < 92) begin
			r.mode       = MODE_FREE;
			r.page_frame = FRAME_W'($urandom_range(0, span * WORD_BITS - 1));
		end else begin
			r.mode       = MODE_FREE;
			r.page_frame = FRAME_W'($urandom_range(0, FRAME_MAX));
		end
		return r;
	endfunction

	// offer one request and return at the edge that takes it
	task automatic send(input in_t req);
		in_valid <= 1'b1;
		in_data  <= req;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sent++;
	endtask

	// bursts of random length with random gaps between them
	task automatic pace();
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			if ($urandom_range(0, 3) != 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 10)) @(posedge clk);
			end
		end
		burst_left--;
	endtask

	// stop offering and wait until every result has come back
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic write_word_count(input logic [WIU_W-1:0] value);
		drain();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
	endtask

	// stimulus: directed cases, then random phases over several word counts
	initial begin
		phase_count[0] = 8'd1;
		phase_count[1] = 8'd2;
		phase_count[2] = 8'd4;
		phase_count[3] = WIU_RESET;
		phase_count[4] = 8'd255;
		phase_count[5] = WIU_W'($urandom_range(1, 8));
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// every kernel / writable mix, already allocated and frame zero
		send(make_req(MODE_ALLOC, 0, 1'b0, 1'b1));
		send(make_req(MODE_ALLOC, 0, 1'b1, 1'b0));
		send(make_req(MODE_ALLOC, 0, 1'b1, 1'b1));
		send(make_req(MODE_ALLOC, 0, 1'b0, 1'b0));
		send(make_req(MODE_ALLOC, FRAME_MAX, 1'b1, 1'b1));
		send(make_req(MODE_ALLOC, 1, 1'b0, 1'b1));
		send(make_req(MODE_FREE, 0, 1'b1, 1'b1));
		send(make_req(MODE_FREE, 1, 1'b0, 1'b0));
		send(make_req(MODE_ALLOC, 0, 1'b0, 1'b1));
		send(make_req(MODE_FREE, FRAME_MAX, 1'b0, 1'b0));
		send(make_req(MODE_FREE, 2, 1'b1, 1'b1));

		// no words searched: an allocate of frame zero runs out of frames
		write_word_count(8'd0);
		send(make_req(MODE_ALLOC, 0, 1'b0, 1'b1));
		send(make_req(MODE_ALLOC, 5, 1'b1, 1'b0));

		// word count above the bitmap size saturates
		write_word_count(8'd255);
		send(make_req(MODE_ALLOC, 0, 1'b1, 1'b1));

		// one word: freeing a frame past the searched words still clears it
		write_word_count(8'd1);
		send(make_req(MODE_FREE, 3, 1'b0, 1'b0));
		send(make_req(MODE_FREE, 40, 1'b1, 1'b0));
		send(make_req(MODE_ALLOC, 0, 1'b0, 1'b0));

		// random phases, the long receiver hold-off early in the third one
		for (int p = 0; p < PHASES; p++) begin
			write_word_count(phase_count[p]);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (p == 2 && i == 5)
					hold_req <= 1'b1;
				send(random_req(phase_count[p]));
				pace();
			end
		end

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("%0d requests over %0d word-count settings, %0d results checked",
			sent, PHASES + 4, results_checked);
		$display("%0d ended out of frames, %0d freed a frame", no_frames_seen, frees_seen);
		if (mismatches == 0 && pending == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	// receiver: changing stall styles, plus one long hold-off on request
	initial begin : receiver
		int unsigned style, style_left, hold_left;
		logic        held;
		style      = 0;
		style_left = 0;
		hold_left  = 0;
		held       = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req && !held) begin
				held      = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				if (style_left == 0) begin
					style      = $urandom_range(0, 3);
					style_left = $urandom_range(20, 300);
				end
				style_left--;
				case (style)
					0: begin
						out_stall <= 1'b0;
					end
					1: begin
						out_stall <= ($urandom_range(0, 3) == 0);
					end
					2: begin
						out_stall <= ($urandom_range(0, 3) != 0);
					end
					default: begin
						out_stall <= ~out_stall;
					end
				endcase
			end
		end
	end

	// watchdog on cycles with no transaction on either channel
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("%0t ns: no transaction for %0d cycles", $time, IDLE_LIMIT);
			$display("Simulation FAILED");
			$finish;
		end
	end

endmodule
